>>> rtl/core/assert_macros.svh
// assertion macros shared by the lexer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/jtl_pkg.sv
// shared types, codes and character helpers of the json token lexer
package jtl_pkg;

	localparam int LINE_BITS_DEF   = 24;
	localparam int COLUMN_BITS_DEF = 16;
	localparam int LENGTH_BITS_DEF = 16;

	localparam int CHAR_W = 8;
	localparam int KIND_W = 2;
	localparam int TYPE_W = 4;
	localparam int LINE_W = 24;
	localparam int COL_W  = 16;
	localparam int LEN_W  = 16;

	// power of two, pointers wrap on their own
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int SLOTS       = 3;

	// record kinds
	localparam logic [KIND_W-1:0] KIND_BODY  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

	// token types
	localparam logic [TYPE_W-1:0] TT_SKIP   = 4'd0;
	localparam logic [TYPE_W-1:0] TT_STRING = 4'd1;
	localparam logic [TYPE_W-1:0] TT_LBRACE = 4'd2;
	localparam logic [TYPE_W-1:0] TT_RBRACE = 4'd3;
	localparam logic [TYPE_W-1:0] TT_LBRACK = 4'd4;
	localparam logic [TYPE_W-1:0] TT_RBRACK = 4'd5;
	localparam logic [TYPE_W-1:0] TT_COLON  = 4'd6;
	localparam logic [TYPE_W-1:0] TT_COMMA  = 4'd7;
	localparam logic [TYPE_W-1:0] TT_BOOL   = 4'd8;
	localparam logic [TYPE_W-1:0] TT_NUM    = 4'd9;

	// characters
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
	localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
	localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
	localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
	localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CHAR_W-1:0] body_char;
		logic [TYPE_W-1:0] token_type;
		logic [LINE_W-1:0] start_line;
		logic [COL_W-1:0]  start_column;
		logic [LEN_W-1:0]  token_length;
	} rec_t;

	// one packet per input item: up to three records in output order
	typedef struct packed {
		logic [SLOTS-1:0]  mask;
		rec_t [SLOTS-1:0]  rec;
	} pkt_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	function automatic logic [TYPE_W-1:0] struct_type(input logic [CHAR_W-1:0] c);
		logic [TYPE_W-1:0] t;
		case (c)
			CH_LBRACE: t = TT_LBRACE;
			CH_RBRACE: t = TT_RBRACE;
			CH_LBRACK: t = TT_LBRACK;
			CH_RBRACK: t = TT_RBRACK;
			CH_COLON:  t = TT_COLON;
			CH_COMMA:  t = TT_COMMA;
			default:   t = TT_SKIP;
		endcase
		return t;
	endfunction

	// letters of "true"
	function automatic logic [CHAR_W-1:0] true_char(input logic [2:0] i);
		logic [CHAR_W-1:0] r;
		case (i)
			3'd0:    r = 8'h74;
			3'd1:    r = 8'h72;
			3'd2:    r = 8'h75;
			3'd3:    r = 8'h65;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// letters of "false"
	function automatic logic [CHAR_W-1:0] false_char(input logic [2:0] i);
		logic [CHAR_W-1:0] r;
		case (i)
			3'd0:    r = 8'h66;
			3'd1:    r = 8'h61;
			3'd2:    r = 8'h6C;
			3'd3:    r = 8'h73;
			3'd4:    r = 8'h65;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/jtl_if.sv
// valid/ready channels for input bytes and result items
interface jtl_in_if;
	import jtl_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] ch;
	logic              at_end;

	modport source (output valid, output ch, output at_end, input ready);
	modport sink (input valid, input ch, input at_end, output ready);
endinterface

interface jtl_out_if;
	import jtl_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [CHAR_W-1:0] body_char;
	logic [TYPE_W-1:0] token_type;
	logic [LINE_W-1:0] start_line;
	logic [COL_W-1:0]  start_column;
	logic [LEN_W-1:0]  token_length;
	logic              last;

	modport source (output valid, output kind, output body_char, output token_type,
		output start_line, output start_column, output token_length, output last,
		input ready);
	modport sink (input valid, input kind, input body_char, input token_type,
		input start_line, input start_column, input token_length, input last,
		output ready);
endinterface

>>> rtl/core/jtl_front.sv
// lexer front: accepts bytes, updates the lexer state and builds result packets
module jtl_front #(
	parameter int LINE_BITS   = jtl_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = jtl_pkg::COLUMN_BITS_DEF,
	parameter int LENGTH_BITS = jtl_pkg::LENGTH_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	jtl_in_if.sink         text,
	input  jtl_pkg::qstat_t qstat,
	output logic           push,
	output jtl_pkg::pkt_t  push_pkt
);
	import jtl_pkg::*;
	`include "assert_macros.svh"

	typedef enum logic [1:0] {MODE_IDLE, MODE_SKIP, MODE_STRING, MODE_WORD} mode_t;

	localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
	localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
	localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;

	mode_t                  mode_q;
	logic                   esc_q;
	logic [LINE_BITS-1:0]   line_q;
	logic [COLUMN_BITS-1:0] col_q;
	logic [LINE_BITS-1:0]   tl_q;
	logic [COLUMN_BITS-1:0] tc_q;
	logic [TYPE_W-1:0]      tk_q;
	logic [1:0]             wm_q;
	logic [LENGTH_BITS-1:0] len_q;

	logic                   accept;
	logic [CHAR_W-1:0]      c;
	logic                   sp, qt, bs, delim;
	logic [TYPE_W-1:0]      st;
	logic                   pre_close;
	mode_t                  mode_m, mode_b, mode_c;
	logic [LENGTH_BITS-1:0] len_m, len_base, len_b;
	logic [1:0]             wm_m, wm_base, wm_b;
	logic                   nl;
	logic [COLUMN_BITS-1:0] col_n;
	logic [LINE_BITS-1:0]   line_n;
	logic                   esc_n, body, starting, close_c, err, tail_v;
	logic [LINE_BITS-1:0]   tl_b;
	logic [COLUMN_BITS-1:0] tc_b;
	logic [TYPE_W-1:0]      tk_b;
	rec_t                   rec_a, rec_body, rec_end, rec_err;

	function automatic logic [TYPE_W-1:0] word_type(input logic [1:0] wm,
		input logic [LENGTH_BITS-1:0] len);
		return ((wm[0] && len == LENGTH_BITS'(4)) || (wm[1] && len == LENGTH_BITS'(5)))
			? TT_BOOL : TT_NUM;
	endfunction

	assign accept     = text.valid && text.ready;
	assign text.ready = !qstat.full;

	always_comb begin
		c     = text.ch;
		sp    = is_space(c);
		st    = struct_type(c);
		qt    = (c == CH_QUOTE);
		bs    = (c == CH_BSLASH);
		delim = sp || (st != TT_SKIP) || qt;

		// a byte that ends a whitespace run or bare word closes it first
		pre_close = !esc_q && ((mode_q == MODE_SKIP && !sp) || (mode_q == MODE_WORD && delim));
		rec_a              = '0;
		rec_a.kind         = KIND_END;
		rec_a.token_type   = (mode_q == MODE_WORD) ? word_type(wm_q, len_q) : tk_q;
		rec_a.start_line   = LINE_W'(tl_q);
		rec_a.start_column = COL_W'(tc_q);
		rec_a.token_length = LEN_W'(len_q);

		mode_m = pre_close ? MODE_IDLE : mode_q;
		len_m  = pre_close ? '0 : len_q;
		wm_m   = pre_close ? 2'b11 : wm_q;

		// position, escaped newline only counts as a column
		nl     = !esc_q && (c == CH_LF);
		col_n  = (col_q == COL_MAX) ? col_q : col_q + COLUMN_BITS'(1);
		line_n = line_q;
		if (nl) begin
			col_n = '0;
			if (line_q != LINE_MAX)
				line_n = line_q + LINE_BITS'(1);
		end

		esc_n    = !esc_q && bs;
		body     = !esc_n;
		starting = body && (mode_m == MODE_IDLE);

		if (starting) begin
			tl_b     = line_n;
			tc_b     = col_n;
			len_base = '0;
			wm_base  = 2'b11;
			if (sp) begin
				tk_b = TT_SKIP;   mode_b = MODE_SKIP;
			end else if (qt) begin
				tk_b = TT_STRING; mode_b = MODE_STRING;
			end else if (st != TT_SKIP) begin
				tk_b = st;        mode_b = MODE_IDLE;
			end else begin
				tk_b = TT_NUM;    mode_b = MODE_WORD;
			end
		end else begin
			tl_b     = tl_q;
			tc_b     = tc_q;
			len_base = len_m;
			wm_base  = wm_m;
			tk_b     = tk_q;
			mode_b   = mode_m;
		end

		// keyword tracking and length count of the body byte
		wm_b  = wm_base;
		len_b = len_base;
		if (body) begin
			if (mode_b == MODE_WORD) begin
				if (!(len_base < LENGTH_BITS'(4) && c == true_char(len_base[2:0])))
					wm_b[0] = 1'b0;
				if (!(len_base < LENGTH_BITS'(5) && c == false_char(len_base[2:0])))
					wm_b[1] = 1'b0;
			end
			if (len_base != LEN_MAX)
				len_b = len_base + LENGTH_BITS'(1);
		end

		close_c = (starting && st != TT_SKIP)
			|| (body && !starting && !esc_q && mode_m == MODE_STRING && qt);
		mode_c = close_c ? MODE_IDLE : mode_b;

		rec_body           = '0;
		rec_body.kind      = KIND_BODY;
		rec_body.body_char = c;

		rec_end              = '0;
		rec_end.kind         = KIND_END;
		rec_end.token_type   = (mode_b == MODE_WORD) ? word_type(wm_b, len_b) : tk_b;
		rec_end.start_line   = LINE_W'(tl_b);
		rec_end.start_column = COL_W'(tc_b);
		rec_end.token_length = LEN_W'(len_b);

		err                  = esc_n || mode_c == MODE_STRING;
		rec_err              = '0;
		rec_err.kind         = KIND_ERROR;
		rec_err.start_line   = LINE_W'(line_n);
		rec_err.start_column = COL_W'(col_n);

		// third slot: closing record of this byte, or the end-of-text record
		tail_v = close_c || (text.at_end && (err || mode_c != MODE_IDLE));

		push_pkt.mask   = {tail_v, body, pre_close};
		push_pkt.rec[0] = rec_a;
		push_pkt.rec[1] = rec_body;
		push_pkt.rec[2] = (close_c || !err) ? rec_end : rec_err;
	end

	assign push = accept && (push_pkt.mask != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			esc_q  <= 1'b0;
			line_q <= '0;
			col_q  <= '0;
			tl_q   <= '0;
			tc_q   <= '0;
			tk_q   <= TT_SKIP;
			wm_q   <= 2'b11;
			len_q  <= '0;
		end else if (accept) begin
			if (text.at_end) begin
				mode_q <= MODE_IDLE;
				esc_q  <= 1'b0;
				line_q <= '0;
				col_q  <= '0;
				tl_q   <= '0;
				tc_q   <= '0;
				tk_q   <= TT_SKIP;
				wm_q   <= 2'b11;
				len_q  <= '0;
			end else begin
				mode_q <= mode_c;
				esc_q  <= esc_n;
				line_q <= line_n;
				col_q  <= col_n;
				tl_q   <= tl_b;
				tc_q   <= tc_b;
				tk_q   <= tk_b;
				wm_q   <= close_c ? 2'b11 : wm_b;
				len_q  <= close_c ? '0 : len_b;
			end
		end
	end

	`ASSERT_NEXT(a_end_resets, clk, arst_n, accept && text.at_end,
		mode_q == MODE_IDLE && !esc_q && line_q == '0, "state not cleared after last byte")
	`ASSERT_SAME(a_escape_no_body, clk, arst_n, accept && esc_n, !push_pkt.mask[1],
		"backslash produced a body record")

endmodule

>>> rtl/core/jtl_queue.sv
// short packet queue between lexer front and result serializer
module jtl_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  jtl_pkg::pkt_t   push_pkt,
	input  logic            pop,
	output jtl_pkg::pkt_t   head,
	output jtl_pkg::qstat_t qstat
);
	import jtl_pkg::*;
	`include "assert_macros.svh"

	pkt_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   count_q;

	assign qstat.full  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head        = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_pkt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QPTR_W'(1);
			if (pop)
				rd_q <= rd_q + QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + (QPTR_W + 1)'(1);
			else if (pop && !push)
				count_q <= count_q - (QPTR_W + 1)'(1);
		end
	end

	`ASSERT_SAME(a_no_overflow, clk, arst_n, push, !qstat.full, "push into full queue")
	`ASSERT_SAME(a_no_underflow, clk, arst_n, pop, !qstat.empty, "pop from empty queue")
	`ASSERT_ALWAYS(a_count_range, clk, arst_n, count_q <= (QPTR_W + 1)'(QUEUE_DEPTH),
		"queue count beyond depth")

endmodule

>>> rtl/core/jtl_back.sv
// result serializer: sends the records of the head packet one item per cycle while the receiver is ready
module jtl_back (
	input  logic            clk,
	input  logic            arst_n,
	input  jtl_pkg::qstat_t qstat,
	input  jtl_pkg::pkt_t   head,
	output logic            pop,
	jtl_out_if.source       token
);
	import jtl_pkg::*;
	`include "assert_macros.svh"

	logic [SLOTS-1:0] done_q;
	logic [SLOTS-1:0] rem, sel_oh;
	logic             last;
	rec_t             rec;
	logic             fire;

	always_comb begin
		rem = head.mask & ~done_q;
		// lowest pending slot goes first
		if (rem[0]) begin
			sel_oh = 3'b001;
			rec    = head.rec[0];
			last   = !rem[1] && !rem[2];
		end else if (rem[1]) begin
			sel_oh = 3'b010;
			rec    = head.rec[1];
			last   = !rem[2];
		end else begin
			sel_oh = 3'b100;
			rec    = head.rec[2];
			last   = 1'b1;
		end
	end

	assign token.valid        = !qstat.empty;
	assign token.kind         = rec.kind;
	assign token.body_char    = rec.body_char;
	assign token.token_type   = rec.token_type;
	assign token.start_line   = rec.start_line;
	assign token.start_column = rec.start_column;
	assign token.token_length = rec.token_length;
	assign token.last         = last;

	assign fire = token.valid && token.ready;
	assign pop  = fire && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (fire) begin
			if (last)
				done_q <= '0;
			else
				done_q <= done_q | sel_oh;
		end
	end

	`ASSERT_SAME(a_head_has_work, clk, arst_n, token.valid, rem != '0,
		"queued packet with no pending record")

endmodule

>>> rtl/core/json_token_lexer_unit.sv
// top level of the json token lexer
//
// text channel: one raw json byte per item (ch), at_end marks the final byte of
// a text; the open token is closed or an error reported after it, and the
// lexer state returns to its reset values so the next byte starts a new text
// token channel: result items in stream order; kind gives body character,
// token end record or format error, last marks the final item caused by one
// input byte (a backslash that starts an escape causes no body item)
// queueing: the items of a byte are registered in the packet queue and offered
// from its head; an input byte may cause up to three items
// throughput: one byte per cycle while the receiver is ready and each byte
// yields at most one item; the output port sends one item per cycle, so a byte
// yielding two or three items holds the output for each of them, and the
// four-entry packet queue between the front and the serializer absorbs bursts
// reset: arst_n clears the lexer state (idle, line and column zero) and
// empties the queue; no clearing pass is needed
// receiver stall: results wait in the queue; text.ready drops only once all
// four queue entries are occupied
module json_token_lexer_unit #(
	parameter int LINE_BITS   = jtl_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = jtl_pkg::COLUMN_BITS_DEF,
	parameter int LENGTH_BITS = jtl_pkg::LENGTH_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	jtl_in_if.sink    text,
	jtl_out_if.source token
);
	import jtl_pkg::*;

	// front to queue
	logic   push;
	pkt_t   push_pkt;
	// queue to serializer
	pkt_t   head;
	logic   pop;
	qstat_t qstat;

	// classification, position counters and token state; at most one packet per byte
	jtl_front #(
		.LINE_BITS  (LINE_BITS),
		.COLUMN_BITS(COLUMN_BITS),
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text),
		.qstat   (qstat),
		.push    (push),
		.push_pkt(push_pkt)
	);

	// decouples the front from stalls on the result side
	jtl_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_pkt(push_pkt),
		.pop     (pop),
		.head    (head),
		.qstat   (qstat)
	);

	// walks the valid records of the head packet, one item per cycle while the receiver is ready
	jtl_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.qstat (qstat),
		.head  (head),
		.pop   (pop),
		.token (token)
	);

endmodule
